// File: rtl/core/xrg_pkg.sv
// Shared types and constants for the xoshiro256** generator.
// Used by the serial multiplier, the serial modulo unit, the seeder and the top level.
package xrg_pkg;

   localparam int WORD_W   = 64;
   localparam int SPAN_W   = 33;
   localparam int INT_W    = 32;
   localparam int FRAC_W   = 23;
   localparam int CNT_W    = 6;

   localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(WORD_W - 1);

   localparam logic [WORD_W-1:0] SEED_DEFAULT = 64'h1234_5678_9ABC_DEF0;
   localparam logic [WORD_W-1:0] GOLDEN_STEP  = 64'h9e37_79b9_7f4a_7c15;
   localparam logic [WORD_W-1:0] MIX_MUL_A    = 64'hbf58_476d_1ce4_e5b9;
   localparam logic [WORD_W-1:0] MIX_MUL_B    = 64'h94d0_49bb_1331_11eb;

   localparam int MIX_SHIFT_A = 30;
   localparam int MIX_SHIFT_B = 27;
   localparam int MIX_SHIFT_C = 31;
   localparam int XS_SHIFT    = 17;
   localparam int XS_ROTATE   = 45;
   localparam int SAMPLE_ROT  = 7;

   typedef enum logic [1:0] {
      KIND_RAW   = 2'd0,
      KIND_RANGE = 2'd1,
      KIND_FRAC  = 2'd2
   } kind_type;

   // One state word written by the seeder.
   typedef struct packed {
      logic              valid;
      logic              last;
      logic [1:0]        idx;
      logic [WORD_W-1:0] data;
   } seed_wr_type;

   typedef struct packed {
      logic              done;
      logic [WORD_W-1:0] product;
   } mul_res_type;

   typedef struct packed {
      logic             done;
      logic [INT_W-1:0] rem;
   } mod_res_type;

   function automatic logic [WORD_W-1:0] rot_left(input logic [WORD_W-1:0] v,
                                                  input int unsigned k);
      return (v << k) | (v >> (WORD_W - k));
   endfunction

endpackage

// File: rtl/core/xrg_serial_mult.sv
// Shift-and-add multiplier, one multiplier bit per cycle, low 64 bits of the product.
// Depends on xrg_pkg.
module xrg_serial_mult
   import xrg_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [WORD_W-1:0] multiplicand,
   input  logic [WORD_W-1:0] multiplier,
   output mul_res_type       res
);

   logic [WORD_W-1:0] acc_ff, acc_in;
   logic [WORD_W-1:0] mcand_ff, mcand_in;
   logic [WORD_W-1:0] mplier_ff, mplier_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         acc_in    = '0;
         mcand_in  = multiplicand;
         mplier_in = multiplier;
         cnt_in    = '0;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
         cnt_in    = cnt_ff + 1'b1;
         if (cnt_ff == STEP_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign res.done    = done_ff;
   assign res.product = acc_ff;

   // A new operand pair must never cut into a product still being formed.
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("multiplier started while busy");

endmodule

// File: rtl/core/xrg_serial_mod.sv
// Restoring modulo unit: 64-bit dividend by a 33-bit divisor, one dividend bit per cycle.
// Depends on xrg_pkg.
module xrg_serial_mod
   import xrg_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [WORD_W-1:0] dividend,
   input  logic [SPAN_W-1:0] divisor,
   output mod_res_type       res
);

   logic [SPAN_W-1:0] rem_ff, rem_in;
   logic [WORD_W-1:0] dvd_ff, dvd_in;
   logic [SPAN_W-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [SPAN_W:0]   trial;
   logic [SPAN_W+1:0] diff;

   // The partial remainder stays below the divisor, so the trial value fits one extra bit.
   assign trial = {rem_ff, dvd_ff[WORD_W-1]};
   assign diff  = {1'b0, trial} - {2'b00, dsr_ff};

   always_comb begin
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[SPAN_W+1]) begin
            rem_in = diff[SPAN_W-1:0];
         end else begin
            rem_in = trial[SPAN_W-1:0];
         end
         dvd_in = dvd_ff << 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign res.done = done_ff;
   assign res.rem  = rem_ff[INT_W-1:0];

endmodule

// File: rtl/core/xrg_seeder.sv
// Splitmix64 seed expansion: produces the four state words one after another.
// Depends on xrg_pkg and xrg_serial_mult.
module xrg_seeder
   import xrg_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [WORD_W-1:0] seed,
   output seed_wr_type       wr
);

   typedef enum logic [3:0] {
      SD_IDLE  = 4'b0001,
      SD_STEP  = 4'b0010,
      SD_MUL_A = 4'b0100,
      SD_MUL_B = 4'b1000
   } sd_state_type;

   sd_state_type      state_ff, state_in;
   logic [WORD_W-1:0] x_ff, x_in;
   logic [1:0]        idx_ff, idx_in;
   logic [WORD_W-1:0] x_sum;
   logic              mul_start;
   logic [WORD_W-1:0] mul_a;
   logic [WORD_W-1:0] mul_b;
   mul_res_type       mul_res;

   assign x_sum = x_ff + GOLDEN_STEP;

   xrg_serial_mult u_mult (
      .clock        (clock),
      .reset        (reset),
      .start        (mul_start),
      .multiplicand (mul_a),
      .multiplier   (mul_b),
      .res          (mul_res)
   );

   always_comb begin
      state_in  = state_ff;
      x_in      = x_ff;
      idx_in    = idx_ff;
      mul_start = 1'b0;
      mul_a     = x_sum ^ (x_sum >> MIX_SHIFT_A);
      mul_b     = MIX_MUL_A;
      wr        = '0;
      case (state_ff)
         SD_IDLE: begin
            if (start) begin
               x_in     = seed;
               idx_in   = '0;
               state_in = SD_STEP;
            end
         end
         SD_STEP: begin
            x_in      = x_sum;
            mul_start = 1'b1;
            state_in  = SD_MUL_A;
         end
         SD_MUL_A: begin
            if (mul_res.done) begin
               mul_start = 1'b1;
               mul_a     = mul_res.product ^ (mul_res.product >> MIX_SHIFT_B);
               mul_b     = MIX_MUL_B;
               state_in  = SD_MUL_B;
            end
         end
         SD_MUL_B: begin
            if (mul_res.done) begin
               wr.valid = 1'b1;
               wr.idx   = idx_ff;
               wr.data  = mul_res.product ^ (mul_res.product >> MIX_SHIFT_C);
               wr.last  = (idx_ff == 2'b11);
               idx_in   = idx_ff + 1'b1;
               state_in = (idx_ff == 2'b11) ? SD_IDLE : SD_STEP;
            end
         end
         default: begin
            state_in = SD_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SD_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
   end

endmodule

// File: rtl/core/xoshiro256ss_random_generator_top.sv
// Channel | Direction | Handshake        | Word
// req     | in        | valid / stall    | kind, range_min, range_max
// rsp     | out       | valid / stall    | raw_word, int_value, fraction
// csr     | in        | valid / ready    | seed_value
//
// Raw and fraction words pass from acceptance through ST_ADV, ST_SCRAM and ST_DONE into the
// output register, and the next request is taken back in ST_IDLE. Range requests add the
// bit-serial modulo unit in ST_DIV, while ranges whose minimum is not below the maximum and
// the unused kind go from acceptance straight to ST_DONE. Reset and every seed write run
// splitmix64 expansion through the bit-serial multiplier, eight products in all, during
// which no word is accepted. A seed write on offer holds off requests, and a new request
// is taken while the previous result still waits under rsp_stall.
// Depends on xrg_pkg, xrg_seeder and xrg_serial_mod.
module xoshiro256ss_random_generator_top
   import xrg_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_kind,
   input  logic signed [INT_W-1:0] req_range_min,
   input  logic signed [INT_W-1:0] req_range_max,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [WORD_W-1:0]       rsp_raw_word,
   output logic signed [INT_W-1:0] rsp_int_value,
   output logic [FRAC_W-1:0]       rsp_fraction,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [WORD_W-1:0]       csr_seed_value
);

   typedef enum logic [6:0] {
      ST_SEED_GO   = 7'b0000001,
      ST_SEED_WAIT = 7'b0000010,
      ST_IDLE      = 7'b0000100,
      ST_ADV       = 7'b0001000,
      ST_SCRAM     = 7'b0010000,
      ST_DIV       = 7'b0100000,
      ST_DONE      = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   logic [WORD_W-1:0] seed_ff, seed_in;
   logic [WORD_W-1:0] w0_ff, w0_in;
   logic [WORD_W-1:0] w1_ff, w1_in;
   logic [WORD_W-1:0] w2_ff, w2_in;
   logic [WORD_W-1:0] w3_ff, w3_in;
   logic [1:0]        kind_ff, kind_in;
   logic [INT_W-1:0]  min_ff, min_in;
   logic [SPAN_W-1:0] span_ff, span_in;
   logic [WORD_W-1:0] p5_ff, p5_in;
   logic [WORD_W-1:0] res_raw_ff, res_raw_in;
   logic [INT_W-1:0]  res_int_ff, res_int_in;
   logic [FRAC_W-1:0] res_frac_ff, res_frac_in;
   logic              out_valid_ff, out_valid_in;
   logic [WORD_W-1:0] out_raw_ff;
   logic [INT_W-1:0]  out_int_ff;
   logic [FRAC_W-1:0] out_frac_ff;

   logic              accept;
   logic              csr_wr;
   logic              out_load;
   logic              range_ok;
   logic [SPAN_W-1:0] req_span;
   logic              seed_start;
   seed_wr_type       seed_wr;
   logic              mod_start;
   mod_res_type       mod_res;
   logic [WORD_W-1:0] adv_t;
   logic [WORD_W-1:0] adv_x2;
   logic [WORD_W-1:0] adv_x3;
   logic [WORD_W-1:0] scram_rot;
   logic [WORD_W-1:0] raw_val;

   // A seed write takes precedence, so a request offered beside it is held off.
   assign req_stall = (state_ff != ST_IDLE) || csr_valid;
   assign csr_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign csr_wr    = csr_valid && csr_ready;

   // The span is formed in 33 bits, so a full-width signed range cannot wrap.
   assign range_ok = (req_range_min < req_range_max);
   assign req_span = {req_range_max[INT_W-1], req_range_max}
                   - {req_range_min[INT_W-1], req_range_min} + SPAN_W'(1);

   // xoshiro256 state transition, all taken from the words before the step.
   assign adv_t  = w1_ff << XS_SHIFT;
   assign adv_x2 = w2_ff ^ w0_ff;
   assign adv_x3 = w3_ff ^ w1_ff;

   assign scram_rot = rot_left(p5_ff, SAMPLE_ROT);
   assign raw_val   = {scram_rot[WORD_W-4:0], 3'b000} + scram_rot;

   xrg_seeder u_seeder (
      .clock (clock),
      .reset (reset),
      .start (seed_start),
      .seed  (seed_ff),
      .wr    (seed_wr)
   );

   xrg_serial_mod u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (raw_val),
      .divisor  (span_ff),
      .res      (mod_res)
   );

   always_comb begin
      state_in    = state_ff;
      seed_in     = seed_ff;
      w0_in       = w0_ff;
      w1_in       = w1_ff;
      w2_in       = w2_ff;
      w3_in       = w3_ff;
      kind_in     = kind_ff;
      min_in      = min_ff;
      span_in     = span_ff;
      p5_in       = p5_ff;
      res_raw_in  = res_raw_ff;
      res_int_in  = res_int_ff;
      res_frac_in = res_frac_ff;
      seed_start  = 1'b0;
      mod_start   = 1'b0;
      out_load    = 1'b0;

      if (seed_wr.valid) begin
         case (seed_wr.idx)
            2'b00:   w0_in = seed_wr.data;
            2'b01:   w1_in = seed_wr.data;
            2'b10:   w2_in = seed_wr.data;
            default: w3_in = seed_wr.data;
         endcase
      end

      case (state_ff)
         ST_SEED_GO: begin
            seed_start = 1'b1;
            state_in   = ST_SEED_WAIT;
         end
         ST_SEED_WAIT: begin
            if (seed_wr.valid && seed_wr.last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (csr_wr) begin
               seed_in  = csr_seed_value;
               state_in = ST_SEED_GO;
            end else if (accept) begin
               kind_in     = req_kind;
               min_in      = req_range_min;
               span_in     = req_span;
               res_raw_in  = '0;
               res_int_in  = '0;
               res_frac_in = '0;
               case (req_kind)
                  KIND_RAW, KIND_FRAC: begin
                     state_in = ST_ADV;
                  end
                  KIND_RANGE: begin
                     if (range_ok) begin
                        state_in = ST_ADV;
                     end else begin
                        res_int_in = req_range_min;
                        state_in   = ST_DONE;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_ADV: begin
            p5_in = {w1_ff[WORD_W-3:0], 2'b00} + w1_ff;
            w0_in = w0_ff ^ adv_x3;
            w1_in = w1_ff ^ adv_x2;
            w2_in = adv_x2 ^ adv_t;
            w3_in = rot_left(adv_x3, XS_ROTATE);
            state_in = ST_SCRAM;
         end
         ST_SCRAM: begin
            res_raw_in = raw_val;
            if (kind_ff == KIND_RANGE) begin
               mod_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               if (kind_ff == KIND_FRAC) begin
                  res_frac_in = raw_val[WORD_W-1 -: FRAC_W];
               end
               state_in = ST_DONE;
            end
         end
         ST_DIV: begin
            if (mod_res.done) begin
               res_int_in = min_ff + mod_res.rem;
               state_in   = ST_DONE;
            end
         end
         ST_DONE: begin
            // Move the result on only once the output register is free or being emptied.
            if (!out_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_SEED_GO;
         end
      endcase
   end

   assign out_valid_in = out_load || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SEED_GO;
         seed_ff      <= SEED_DEFAULT;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seed_ff      <= seed_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      w0_ff       <= w0_in;
      w1_ff       <= w1_in;
      w2_ff       <= w2_in;
      w3_ff       <= w3_in;
      kind_ff     <= kind_in;
      min_ff      <= min_in;
      span_ff     <= span_in;
      p5_ff       <= p5_in;
      res_raw_ff  <= res_raw_in;
      res_int_ff  <= res_int_in;
      res_frac_ff <= res_frac_in;
      if (out_load) begin
         out_raw_ff  <= res_raw_ff;
         out_int_ff  <= res_int_ff;
         out_frac_ff <= res_frac_ff;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_raw_word  = out_raw_ff;
   assign rsp_int_value = out_int_ff;
   assign rsp_fraction  = out_frac_ff;

   // An accepted word either starts a state advance or finishes at once.
   a_accept_path: assert property (@(posedge clock) disable iff (reset)
      (!reset && accept) |=> (state_ff == ST_ADV || state_ff == ST_DONE))
      else $error("accepted word took no valid path");

   // A finished result waits while the previous one is still held in the output register.
   a_result_waits: assert property (@(posedge clock) disable iff (reset)
      (!reset && state_ff == ST_DONE && out_valid_ff && rsp_stall) |=> state_ff == ST_DONE)
      else $error("result overwrote an undelivered word");

   // State words are only written by the seeder while reseeding is in progress.
   a_seed_window: assert property (@(posedge clock) disable iff (reset)
      (!reset && seed_wr.valid) |-> state_ff == ST_SEED_WAIT)
      else $error("seeder wrote state outside reseeding");

endmodule
